// ----- rtl/core/ypvm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ypvm_pkg
// Shared widths, types and the quarter-wave sine table builder for the
// yaw/pitch view matrix core.
// ----------------------------------------------------------------------------
package ypvm_pkg;

    localparam int ANGLE_BITS     = 11;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int COORD_W        = 24;
    localparam int MAT_W          = 16;
    localparam int TRANS_W        = 40;

    localparam int QTR_BITS   = ANGLE_BITS - 2;
    localparam int QTR        = 1 << QTR_BITS;
    localparam int IDX_W      = QTR_BITS + 1;
    localparam int MAG_W      = TRIG_FRAC_BITS + 1;
    localparam int PROD_W     = 2 * MAT_W;
    localparam int ROUND_HALF = 1 << (TRIG_FRAC_BITS - 1);

    localparam longint PI_HALF_Q30 = 64'd1686629713;
    localparam int     TAYLOR_N    = 12;

    typedef logic [ANGLE_BITS-1:0]     angle_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [MAT_W-1:0]   trig_t;
    typedef logic signed [TRANS_W-1:0] trans_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [MAG_W-1:0]          mag_t;

    typedef struct packed {
        idx_t idx;
        logic neg;
    } sine_addr_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } cam_t;

    typedef struct packed {
        trig_t sp;
        trig_t cp;
        trig_t sy;
        trig_t cy;
    } trig_set_t;

    typedef struct packed {
        trig_t m0;
        trig_t m1;
        trig_t m2;
        trig_t m5;
        trig_t m6;
        trig_t m8;
        trig_t m9;
        trig_t m10;
    } rot_t;

    typedef struct packed {
        trans_t tx;
        trans_t ty;
        trans_t tz;
    } trans_set_t;

    typedef mag_t sine_rom_t [0:QTR];

    function automatic sine_addr_t sine_addr(input angle_t a);
        sine_addr_t res;
        idx_t       r;
        r = {1'b0, a[QTR_BITS-1:0]};
        res.idx = a[QTR_BITS] ? (idx_t'(QTR) - r) : r;
        res.neg = a[ANGLE_BITS-1];
        return res;
    endfunction

    // Floor quotient of nonnegative values, evaluated only while building the table.
    function automatic longint long_div(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (longint'(1) <<< b);
            end
        end
        return quo;
    endfunction

    function automatic mag_t quarter_sine(input int r);
        longint taylor_div [1:TAYLOR_N];
        longint x;
        longint x2;
        longint term;
        longint sum;
        for (int k = 1; k <= TAYLOR_N; k++) begin
            taylor_div[k] = longint'((2 * k) * (2 * k + 1));
        end
        x    = (longint'(r) * PI_HALF_Q30 + longint'(QTR >> 1)) >>> QTR_BITS;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= TAYLOR_N; k++) begin
            term = (term * x2) >>> 30;
            term = long_div(term, taylor_div[k]);
            if ((k & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + (longint'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
        return mag_t'(sum);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i <= QTR; i++) begin
            rom[i] = quarter_sine(i);
        end
        return rom;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/yaw_pitch_view_matrix_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// yaw_pitch_view_matrix_core
// View matrix from camera position and pitch/yaw angles.
//
// Input channel s_*: camera position (signed integer units) and pitch and yaw
// in 2048-per-turn units. Result channel m_*: the eight non-constant rotation
// entries in signed Q1.14 and three translation entries with 14 fraction bits.
// Both channels are valid/ready; one result transaction per input transaction.
//
// From input acceptance to m_valid there are three stages for the angle
// fold, sine ROM read and sign, two for the trig products and rounding, two
// for the camera products and sums. One transaction enters per cycle unless
// the output stalls. The whole pipeline advances together: when m_valid is
// high and m_ready is low, every stage holds and s_ready drops; nothing is
// lost or repeated. Empty stages hold too while the output waits to be taken.
// Reset clears all valid bits; the block is ready right after reset.
// ----------------------------------------------------------------------------
module yaw_pitch_view_matrix_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ypvm_pkg::coord_t  s_cam_x,
    input  wire ypvm_pkg::coord_t  s_cam_y,
    input  wire ypvm_pkg::coord_t  s_cam_z,
    input  wire ypvm_pkg::angle_t  s_pitch_angle,
    input  wire ypvm_pkg::angle_t  s_yaw_angle,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ypvm_pkg::trig_t        m_mat_0,
    output ypvm_pkg::trig_t        m_mat_1,
    output ypvm_pkg::trig_t        m_mat_2,
    output ypvm_pkg::trig_t        m_mat_5,
    output ypvm_pkg::trig_t        m_mat_6,
    output ypvm_pkg::trig_t        m_mat_8,
    output ypvm_pkg::trig_t        m_mat_9,
    output ypvm_pkg::trig_t        m_mat_10,
    output ypvm_pkg::trans_t       m_trans_x,
    output ypvm_pkg::trans_t       m_trans_y,
    output ypvm_pkg::trans_t       m_trans_z
);
    import ypvm_pkg::*;

    logic       adv;
    cam_t       in_cam;
    logic       trig_valid;
    cam_t       trig_cam;
    trig_set_t  trig_set;
    logic       rot_valid;
    cam_t       rot_cam;
    rot_t       rot;
    logic       out_valid;
    rot_t       out_rot;
    trans_set_t out_trans;

    assign adv     = !out_valid || m_ready;
    assign s_ready = adv;

    assign in_cam.x = s_cam_x;
    assign in_cam.y = s_cam_y;
    assign in_cam.z = s_cam_z;

    ypvm_trig u_trig (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_cam    (in_cam),
        .in_pitch  (s_pitch_angle),
        .in_yaw    (s_yaw_angle),
        .out_valid (trig_valid),
        .out_cam   (trig_cam),
        .out_trig  (trig_set)
    );

    ypvm_rot u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (trig_valid),
        .in_cam    (trig_cam),
        .in_trig   (trig_set),
        .out_valid (rot_valid),
        .out_cam   (rot_cam),
        .out_rot   (rot)
    );

    ypvm_trans u_trans (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (rot_valid),
        .in_cam    (rot_cam),
        .in_rot    (rot),
        .out_valid (out_valid),
        .out_rot   (out_rot),
        .out_trans (out_trans)
    );

    assign m_valid   = out_valid;
    assign m_mat_0   = out_rot.m0;
    assign m_mat_1   = out_rot.m1;
    assign m_mat_2   = out_rot.m2;
    assign m_mat_5   = out_rot.m5;
    assign m_mat_6   = out_rot.m6;
    assign m_mat_8   = out_rot.m8;
    assign m_mat_9   = out_rot.m9;
    assign m_mat_10  = out_rot.m10;
    assign m_trans_x = out_trans.tx;
    assign m_trans_y = out_trans.ty;
    assign m_trans_z = out_trans.tz;

endmodule
`default_nettype wire

// ----- rtl/core/ypvm_sine_rom.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ypvm_sine_rom
// Quarter-wave sine magnitude ROM, two registered read ports.
// ----------------------------------------------------------------------------
module ypvm_sine_rom (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire ypvm_pkg::idx_t addr_a,
    input  wire ypvm_pkg::idx_t addr_b,
    output ypvm_pkg::mag_t     data_a,
    output ypvm_pkg::mag_t     data_b
);
    import ypvm_pkg::*;

    localparam sine_rom_t ROM = build_sine_rom();

    mag_t data_a_reg;
    mag_t data_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_a_reg <= ROM[addr_a];
            data_b_reg <= ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ypvm_trig.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ypvm_trig
// Negate angles, fold into the quarter wave, look up and sign the sine and
// cosine of pitch and yaw. Three register stages.
// ----------------------------------------------------------------------------
module ypvm_trig (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire ypvm_pkg::cam_t    in_cam,
    input  wire ypvm_pkg::angle_t  in_pitch,
    input  wire ypvm_pkg::angle_t  in_yaw,
    output logic                   out_valid,
    output ypvm_pkg::cam_t         out_cam,
    output ypvm_pkg::trig_set_t    out_trig
);
    import ypvm_pkg::*;

    angle_t     np;
    angle_t     ny;
    sine_addr_t sp_addr_next, cp_addr_next, sy_addr_next, cy_addr_next;
    sine_addr_t sp_addr_reg,  cp_addr_reg,  sy_addr_reg,  cy_addr_reg;
    logic [3:0] neg2_reg;
    mag_t       sp_mag, cp_mag, sy_mag, cy_mag;
    trig_set_t  trig_next;
    trig_set_t  trig_reg;
    cam_t       cam1_reg, cam2_reg, cam3_reg;
    logic       v1_reg, v2_reg, v3_reg;

    always_comb begin
        np = angle_t'(0) - in_pitch;
        ny = angle_t'(0) - in_yaw;
        sp_addr_next = sine_addr(np);
        cp_addr_next = sine_addr(np + angle_t'(QTR));
        sy_addr_next = sine_addr(ny);
        cy_addr_next = sine_addr(ny + angle_t'(QTR));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sp_addr_reg <= sp_addr_next;
            cp_addr_reg <= cp_addr_next;
            sy_addr_reg <= sy_addr_next;
            cy_addr_reg <= cy_addr_next;
            cam1_reg    <= in_cam;
            neg2_reg    <= {sp_addr_reg.neg, cp_addr_reg.neg, sy_addr_reg.neg, cy_addr_reg.neg};
            cam2_reg    <= cam1_reg;
            trig_reg    <= trig_next;
            cam3_reg    <= cam2_reg;
        end
    end

    ypvm_sine_rom u_rom_pitch (
        .aclk   (aclk),
        .en     (adv),
        .addr_a (sp_addr_reg.idx),
        .addr_b (cp_addr_reg.idx),
        .data_a (sp_mag),
        .data_b (cp_mag)
    );

    ypvm_sine_rom u_rom_yaw (
        .aclk   (aclk),
        .en     (adv),
        .addr_a (sy_addr_reg.idx),
        .addr_b (cy_addr_reg.idx),
        .data_a (sy_mag),
        .data_b (cy_mag)
    );

    always_comb begin
        trig_next.sp = neg2_reg[3] ? -trig_t'(sp_mag) : trig_t'(sp_mag);
        trig_next.cp = neg2_reg[2] ? -trig_t'(cp_mag) : trig_t'(cp_mag);
        trig_next.sy = neg2_reg[1] ? -trig_t'(sy_mag) : trig_t'(sy_mag);
        trig_next.cy = neg2_reg[0] ? -trig_t'(cy_mag) : trig_t'(cy_mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_cam   = cam3_reg;
    assign out_trig  = trig_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ypvm_rot.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ypvm_rot
// Multiply trig pairs and round half up back to Q1.14; assemble the rotation
// entries. Two register stages.
// ----------------------------------------------------------------------------
module ypvm_rot (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire ypvm_pkg::cam_t     in_cam,
    input  wire ypvm_pkg::trig_set_t in_trig,
    output logic                    out_valid,
    output ypvm_pkg::cam_t          out_cam,
    output ypvm_pkg::rot_t          out_rot
);
    import ypvm_pkg::*;

    typedef logic signed [PROD_W-1:0] prod_t;

    trig_t     sp, cp, sy, cy;
    prod_t     p_sysp_next, p_sycp_next, p_cysp_next, p_cycp_next;
    prod_t     p_sysp_reg,  p_sycp_reg,  p_cysp_reg,  p_cycp_reg;
    prod_t     r_sysp, r_sycp, r_cysp, r_cycp;
    trig_set_t trig4_reg;
    cam_t      cam4_reg, cam5_reg;
    rot_t      rot_next;
    rot_t      rot_reg;
    logic      v4_reg, v5_reg;

    assign sp = in_trig.sp;
    assign cp = in_trig.cp;
    assign sy = in_trig.sy;
    assign cy = in_trig.cy;

    always_comb begin
        p_sysp_next = sy * sp;
        p_sycp_next = sy * cp;
        p_cysp_next = cy * sp;
        p_cycp_next = cy * cp;
    end

    always_comb begin
        r_sysp = (p_sysp_reg + prod_t'(ROUND_HALF)) >>> TRIG_FRAC_BITS;
        r_sycp = (p_sycp_reg + prod_t'(ROUND_HALF)) >>> TRIG_FRAC_BITS;
        r_cysp = (p_cysp_reg + prod_t'(ROUND_HALF)) >>> TRIG_FRAC_BITS;
        r_cycp = (p_cycp_reg + prod_t'(ROUND_HALF)) >>> TRIG_FRAC_BITS;
        rot_next.m0  = trig4_reg.cy;
        rot_next.m1  = r_sysp[MAT_W-1:0];
        rot_next.m2  = r_sycp[MAT_W-1:0];
        rot_next.m5  = trig4_reg.cp;
        rot_next.m6  = -trig4_reg.sp;
        rot_next.m8  = -trig4_reg.sy;
        rot_next.m9  = r_cysp[MAT_W-1:0];
        rot_next.m10 = r_cycp[MAT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_sysp_reg <= p_sysp_next;
            p_sycp_reg <= p_sycp_next;
            p_cysp_reg <= p_cysp_next;
            p_cycp_reg <= p_cycp_next;
            trig4_reg  <= in_trig;
            cam4_reg   <= in_cam;
            rot_reg    <= rot_next;
            cam5_reg   <= cam4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_cam   = cam5_reg;
    assign out_rot   = rot_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ypvm_trans.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ypvm_trans
// Camera-by-column products, then negated two- or three-term sums for the
// translation entries. Two register stages, the last is the output register.
// ----------------------------------------------------------------------------
module ypvm_trans (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            adv,
    input  wire logic            in_valid,
    input  wire ypvm_pkg::cam_t  in_cam,
    input  wire ypvm_pkg::rot_t  in_rot,
    output logic                 out_valid,
    output ypvm_pkg::rot_t       out_rot,
    output ypvm_pkg::trans_set_t out_trans
);
    import ypvm_pkg::*;

    coord_t     cx, cy, cz;
    trig_t      m0, m1, m2, m5, m6, m8, m9, m10;
    trans_t     p_next [0:7];
    trans_t     p_reg  [0:7];
    rot_t       rot6_reg, rot7_reg;
    trans_set_t trans_next;
    trans_set_t trans_reg;
    logic       v6_reg, v7_reg;

    assign cx  = in_cam.x;
    assign cy  = in_cam.y;
    assign cz  = in_cam.z;
    assign m0  = in_rot.m0;
    assign m1  = in_rot.m1;
    assign m2  = in_rot.m2;
    assign m5  = in_rot.m5;
    assign m6  = in_rot.m6;
    assign m8  = in_rot.m8;
    assign m9  = in_rot.m9;
    assign m10 = in_rot.m10;

    always_comb begin
        p_next[0] = cx * m0;
        p_next[1] = cz * m8;
        p_next[2] = cx * m1;
        p_next[3] = cy * m5;
        p_next[4] = cz * m9;
        p_next[5] = cx * m2;
        p_next[6] = cy * m6;
        p_next[7] = cz * m10;
    end

    always_comb begin
        trans_next.tx = -(p_reg[0] + p_reg[1]);
        trans_next.ty = -(p_reg[2] + p_reg[3] + p_reg[4]);
        trans_next.tz = -(p_reg[5] + p_reg[6] + p_reg[7]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 8; i++) begin
                p_reg[i] <= p_next[i];
            end
            rot6_reg  <= in_rot;
            rot7_reg  <= rot6_reg;
            trans_reg <= trans_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= in_valid;
            v7_reg <= v6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign out_rot   = rot7_reg;
    assign out_trans = trans_reg;

endmodule
`default_nettype wire
